// ----- rtl/ism_pkg.sv -----
// Package: shared types and constants for the icon size best match unit.
`timescale 1ns / 1ps
package ism_pkg;

    localparam int unsigned EDGE_W    = 9;
    localparam int unsigned TARGET_W  = 11;
    localparam int unsigned AREA_W    = 17;
    localparam int unsigned DEPTH_W   = 16;
    localparam int unsigned INDEX_W   = 16;
    localparam int unsigned LEN_W     = 20;

    localparam logic [TARGET_W-1:0] TARGET_RESET = 11'd16;
    localparam logic [LEN_W-1:0]    HEADER_BYTES = 20'd6;
    localparam logic [LEN_W-1:0]    ENTRY_BYTES  = 20'd14;
    localparam logic [EDGE_W-1:0]   EDGE_ZERO    = 9'd256;
    localparam logic [15:0]         ICON_TYPE    = 16'd1;

    localparam logic CFG_TARGET_WIDTH  = 1'b0;
    localparam logic CFG_TARGET_HEIGHT = 1'b1;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_ENTRY  = 1'b1;

    typedef enum logic [1:0] {
        CLS_EXACT   = 2'd0,
        CLS_LARGER  = 2'd1,
        CLS_SMALLER = 2'd2,
        CLS_NONE    = 2'd3
    } t_cls;

    typedef struct packed {
        t_cls              cls;
        logic [AREA_W-1:0] area;
        logic [AREA_W-1:0] penalty;
    } t_eval;

endpackage

// ----- rtl/ism_header_check.sv -----
// Directory header validation: reserved word, type and count against length.
`timescale 1ns / 1ps
module ism_header_check
    import ism_pkg::*;
(
    input  logic [15:0]      i_reserved_word,
    input  logic [15:0]      i_type_word,
    input  logic [15:0]      i_entry_count,
    input  logic [LEN_W-1:0] i_directory_bytes,
    output logic             o_ok
);

    logic [LEN_W-1:0] count_bytes;
    logic [LEN_W-1:0] room;
    logic             len_ok;

    // count <= (len - 6) / 14  <=>  14 * count <= len - 6
    assign count_bytes = LEN_W'(i_entry_count) * ENTRY_BYTES;
    assign len_ok      = i_directory_bytes >= HEADER_BYTES;
    assign room        = i_directory_bytes - HEADER_BYTES;

    assign o_ok = len_ok && (i_reserved_word == 16'd0) && (i_type_word == ICON_TYPE) &&
                  (i_entry_count != 16'd0) && (count_bytes <= room);

endmodule

// ----- rtl/ism_entry_eval.sv -----
// Entry classification: size class, area and area excess against the target.
`timescale 1ns / 1ps
module ism_entry_eval
    import ism_pkg::*;
(
    input  logic [7:0]          i_width_byte,
    input  logic [7:0]          i_height_byte,
    input  logic [TARGET_W-1:0] i_target_width,
    input  logic [TARGET_W-1:0] i_target_height,
    output t_eval               o_eval
);

    logic [EDGE_W-1:0]     w;
    logic [EDGE_W-1:0]     h;
    logic [2*EDGE_W-1:0]   area;
    logic [2*EDGE_W-1:0]   target_area;
    logic [2*EDGE_W-1:0]   excess;
    logic                  exact;
    logic                  larger;

    assign w = (i_width_byte == 8'd0)  ? EDGE_ZERO : {1'b0, i_width_byte};
    assign h = (i_height_byte == 8'd0) ? EDGE_ZERO : {1'b0, i_height_byte};

    assign exact  = (TARGET_W'(w) == i_target_width) && (TARGET_W'(h) == i_target_height);
    assign larger = (TARGET_W'(w) >= i_target_width) && (TARGET_W'(h) >= i_target_height);

    // target edges are at most 256 whenever the excess is used
    assign area        = w * h;
    assign target_area = i_target_width[EDGE_W-1:0] * i_target_height[EDGE_W-1:0];
    assign excess      = area - target_area;

    always_comb begin
        o_eval.area = area[AREA_W-1:0];
        if (exact) begin
            o_eval.cls     = CLS_EXACT;
            o_eval.penalty = '0;
        end else if (larger) begin
            o_eval.cls     = CLS_LARGER;
            o_eval.penalty = excess[AREA_W-1:0];
        end else begin
            o_eval.cls     = CLS_SMALLER;
            o_eval.penalty = '0;
        end
    end

endmodule

// ----- rtl/icon_size_best_match_unit.sv -----
// Top level: input register, running best-entry tracker and result register.
// An item passes the input register; its result (if any) is registered at o_out_valid.
// Throughput: one item per cycle unless stalled; the tracker compare is combinational.
// Stall from the result side stops the tracker stage and, behind it, the input register.
// Reset (synchronous, i_rst_n low): both stages empty, no directory open, targets 16 x 16.
`timescale 1ns / 1ps
module icon_size_best_match_unit
    import ism_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [TARGET_W-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_kind,
    input  logic [15:0]         i_reserved_word,
    input  logic [15:0]         i_type_word,
    input  logic [15:0]         i_entry_count,
    input  logic [LEN_W-1:0]    i_directory_bytes,
    input  logic [7:0]          i_width_byte,
    input  logic [7:0]          i_height_byte,
    input  logic [15:0]         i_bit_count,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_found,
    output logic [INDEX_W-1:0]  o_best_index
);

    logic [TARGET_W-1:0] r_target_width;
    logic [TARGET_W-1:0] r_target_height;

    logic                r_s1_valid;
    logic                r_kind;
    logic [15:0]         r_reserved_word;
    logic [15:0]         r_type_word;
    logic [15:0]         r_entry_count;
    logic [LEN_W-1:0]    r_directory_bytes;
    logic [7:0]          r_width_byte;
    logic [7:0]          r_height_byte;
    logic [DEPTH_W-1:0]  r_bit_count;

    logic                r_header_ok;
    logic [INDEX_W-1:0]  r_expected_entries;
    logic [INDEX_W-1:0]  r_entries_seen;
    logic [INDEX_W-1:0]  r_winner_index;
    t_cls                r_winner_class;
    logic [AREA_W-1:0]   r_winner_area;
    logic [AREA_W-1:0]   r_winner_penalty;
    logic [DEPTH_W-1:0]  r_winner_depth;

    logic                r_out_valid;
    logic                r_found;
    logic [INDEX_W-1:0]  r_best_index;

    logic                n_header_ok;
    logic [INDEX_W-1:0]  n_expected_entries;
    logic [INDEX_W-1:0]  n_entries_seen;
    logic [INDEX_W-1:0]  n_winner_index;
    t_cls                n_winner_class;
    logic [AREA_W-1:0]   n_winner_area;
    logic [AREA_W-1:0]   n_winner_penalty;
    logic [DEPTH_W-1:0]  n_winner_depth;
    logic                n_emit;
    logic                n_found;
    logic [INDEX_W-1:0]  n_best_index;

    logic                out_free;
    logic                s1_free;
    logic                fire;
    logic                hdr_ok;
    t_eval               ev;
    logic                take;
    logic [INDEX_W-1:0]  seen_inc;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_free    = !r_s1_valid || out_free;
    assign fire       = r_s1_valid && out_free;
    assign o_in_stall = !s1_free;

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_found;
    assign o_best_index = r_best_index;

    ism_header_check u_header_check (
        .i_reserved_word   (r_reserved_word),
        .i_type_word       (r_type_word),
        .i_entry_count     (r_entry_count),
        .i_directory_bytes (r_directory_bytes),
        .o_ok              (hdr_ok)
    );

    ism_entry_eval u_entry_eval (
        .i_width_byte    (r_width_byte),
        .i_height_byte   (r_height_byte),
        .i_target_width  (r_target_width),
        .i_target_height (r_target_height),
        .o_eval          (ev)
    );

    always_comb begin
        if (ev.cls < r_winner_class) begin
            take = 1'b1;
        end else if (ev.cls == r_winner_class) begin
            case (ev.cls)
                CLS_EXACT:   take = r_bit_count > r_winner_depth;
                CLS_LARGER:  take = (ev.penalty < r_winner_penalty) ||
                                    ((ev.penalty == r_winner_penalty) &&
                                     (r_bit_count > r_winner_depth));
                CLS_SMALLER: take = (ev.area > r_winner_area) ||
                                    ((ev.area == r_winner_area) &&
                                     (r_bit_count > r_winner_depth));
                default:     take = 1'b0;
            endcase
        end else begin
            take = 1'b0;
        end
    end

    assign seen_inc = r_entries_seen + INDEX_W'(1);

    always_comb begin
        n_header_ok        = r_header_ok;
        n_expected_entries = r_expected_entries;
        n_entries_seen     = r_entries_seen;
        n_winner_index     = r_winner_index;
        n_winner_class     = r_winner_class;
        n_winner_area      = r_winner_area;
        n_winner_penalty   = r_winner_penalty;
        n_winner_depth     = r_winner_depth;
        n_emit             = 1'b0;
        n_found            = 1'b0;
        n_best_index       = '0;
        if (r_kind == KIND_HEADER) begin
            n_header_ok        = hdr_ok;
            n_expected_entries = hdr_ok ? r_entry_count : '0;
            n_entries_seen     = '0;
            n_winner_class     = CLS_NONE;
            n_emit             = !hdr_ok;
        end else if (r_header_ok) begin
            if (take) begin
                n_winner_index   = r_entries_seen;
                n_winner_class   = ev.cls;
                n_winner_area    = ev.area;
                n_winner_penalty = ev.penalty;
                n_winner_depth   = r_bit_count;
            end
            n_entries_seen = seen_inc;
            if (seen_inc == r_expected_entries) begin
                n_emit             = 1'b1;
                n_found            = 1'b1;
                n_best_index       = take ? r_entries_seen : r_winner_index;
                n_header_ok        = 1'b0;
                n_expected_entries = '0;
                n_entries_seen     = '0;
                n_winner_class     = CLS_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_width  <= TARGET_RESET;
            r_target_height <= TARGET_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARGET_WIDTH:  r_target_width  <= i_cfg_data;
                CFG_TARGET_HEIGHT: r_target_height <= i_cfg_data;
                default:           r_target_width  <= r_target_width;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_in_valid;
        end
        if (s1_free && i_in_valid) begin
            r_kind            <= i_kind;
            r_reserved_word   <= i_reserved_word;
            r_type_word       <= i_type_word;
            r_entry_count     <= i_entry_count;
            r_directory_bytes <= i_directory_bytes;
            r_width_byte      <= i_width_byte;
            r_height_byte     <= i_height_byte;
            r_bit_count       <= i_bit_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_ok        <= 1'b0;
            r_expected_entries <= '0;
            r_entries_seen     <= '0;
            r_winner_class     <= CLS_NONE;
            r_out_valid        <= 1'b0;
        end else begin
            if (fire) begin
                r_header_ok        <= n_header_ok;
                r_expected_entries <= n_expected_entries;
                r_entries_seen     <= n_entries_seen;
                r_winner_class     <= n_winner_class;
            end
            if (out_free) begin
                r_out_valid <= fire && n_emit;
            end
        end
        if (fire) begin
            r_winner_index   <= n_winner_index;
            r_winner_area    <= n_winner_area;
            r_winner_penalty <= n_winner_penalty;
            r_winner_depth   <= n_winner_depth;
        end
        if (fire && n_emit) begin
            r_found      <= n_found;
            r_best_index <= n_best_index;
        end
    end

`ifndef NO_ASSERTIONS
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_best_index == '0)
        else $error("not-found result with nonzero index");

    a_seen_below_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_header_ok |-> r_entries_seen < r_expected_entries)
        else $error("entry counter reached count with directory still open");

    a_closed_is_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_header_ok |-> (r_winner_class == CLS_NONE) && (r_entries_seen == '0))
        else $error("tracker state left over without open directory");

    a_found_index_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && n_emit && n_found |-> n_best_index <= r_entries_seen)
        else $error("winner index beyond entries seen");
`endif

endmodule

// ----- dv/ism_checker.sv -----
// Checker: predicts the icon best-match results from the observed items and compares them.
`timescale 1ns / 1ps
module ism_checker
    import ism_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [TARGET_W-1:0] i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic                i_kind,
    input  logic [15:0]         i_reserved_word,
    input  logic [15:0]         i_type_word,
    input  logic [15:0]         i_entry_count,
    input  logic [LEN_W-1:0]    i_directory_bytes,
    input  logic [7:0]          i_width_byte,
    input  logic [7:0]          i_height_byte,
    input  logic [15:0]         i_bit_count,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic                i_found,
    input  logic [INDEX_W-1:0]  i_best_index,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] best_index;
    } t_pick;

    t_pick picks_due[$];

    logic [TARGET_W-1:0] tgt_w;
    logic [TARGET_W-1:0] tgt_h;
    logic                dir_open;
    logic [15:0]         entries_due;
    logic [15:0]         entries_done;
    logic                best_valid;
    logic [INDEX_W-1:0]  best_idx;
    t_cls                best_cls;
    logic [AREA_W-1:0]   lead_area;
    logic [AREA_W-1:0]   best_pen;
    logic [DEPTH_W-1:0]  best_depth;
    int                  fails = 0;

    function automatic logic [EDGE_W-1:0] edge_px(input logic [7:0] b);
        return (b == 8'd0) ? EDGE_ZERO : {1'b0, b};
    endfunction

    task automatic close_dir();
        dir_open     = 1'b0;
        entries_due  = '0;
        entries_done = '0;
        best_valid   = 1'b0;
        best_idx     = '0;
        best_cls     = CLS_NONE;
        lead_area    = '0;
        best_pen     = '0;
        best_depth   = '0;
    endtask

    always @(posedge i_clk) begin : track
        int unsigned w;
        int unsigned h;
        int unsigned cx;
        int unsigned cy;
        int unsigned area;
        int unsigned pen;
        int unsigned room;
        t_cls        cls;
        logic        take;
        t_pick       pick;
        if (!i_rst_n) begin
            tgt_w = TARGET_RESET;
            tgt_h = TARGET_RESET;
            close_dir();
            picks_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_TARGET_WIDTH)
                    tgt_w = i_cfg_data;
                else
                    tgt_h = i_cfg_data;
            end

            if (i_in_valid && !i_in_stall) begin
                if (i_kind == KIND_HEADER) begin
                    room = 0;
                    if (i_directory_bytes >= HEADER_BYTES)
                        room = 32'((i_directory_bytes - HEADER_BYTES) / ENTRY_BYTES);
                    close_dir();
                    if (i_directory_bytes >= HEADER_BYTES && i_reserved_word == 16'd0 &&
                        i_type_word == ICON_TYPE && i_entry_count != 16'd0 &&
                        i_entry_count <= room) begin
                        dir_open    = 1'b1;
                        entries_due = i_entry_count;
                    end else begin
                        pick.found      = 1'b0;
                        pick.best_index = '0;
                        picks_due.push_back(pick);
                    end
                end else if (dir_open) begin
                    w  = 32'(edge_px(i_width_byte));
                    h  = 32'(edge_px(i_height_byte));
                    cx = 32'(tgt_w);
                    cy = 32'(tgt_h);
                    if (w == cx && h == cy)
                        cls = CLS_EXACT;
                    else if (w >= cx && h >= cy)
                        cls = CLS_LARGER;
                    else
                        cls = CLS_SMALLER;
                    area = w * h;
                    // only a larger entry's excess is ever compared
                    pen = (cls == CLS_LARGER) ? area - cx * cy : 0;

                    if (!best_valid || cls < best_cls)
                        take = 1'b1;
                    else if (cls == best_cls) begin
                        case (cls)
                            CLS_EXACT: take = i_bit_count > best_depth;
                            CLS_LARGER: take = pen < best_pen ||
                                               (pen == best_pen && i_bit_count > best_depth);
                            default: take = area > lead_area ||
                                            (area == lead_area && i_bit_count > best_depth);
                        endcase
                    end else
                        take = 1'b0;

                    if (take) begin
                        best_valid = 1'b1;
                        best_idx   = entries_done;
                        best_cls   = cls;
                        lead_area  = area[AREA_W-1:0];
                        best_pen   = pen[AREA_W-1:0];
                        best_depth = i_bit_count;
                    end

                    entries_done = entries_done + 16'd1;
                    if (entries_done == entries_due) begin
                        pick.found      = 1'b1;
                        pick.best_index = best_idx;
                        picks_due.push_back(pick);
                        close_dir();
                    end
                end
            end

            if (i_out_valid && !i_out_stall) begin
                if (picks_due.size() == 0) begin
                    $error("result with nothing expected: found=%0d best_index=%0d",
                           i_found, i_best_index);
                    fails++;
                end else begin
                    pick = picks_due.pop_front();
                    if (i_found !== pick.found) begin
                        $error("found mismatch: expected %0d, actual %0d", pick.found, i_found);
                        fails++;
                    end
                    if (i_best_index !== pick.best_index) begin
                        $error("best_index mismatch: expected %0d, actual %0d",
                               pick.best_index, i_best_index);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= picks_due.size();
    end

endmodule

// ----- dv/tb.sv -----
// Testbench top: clock, reset, item and register stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps
module tb;
    import ism_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int STUCK_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 6;

    logic                clk             = 1'b0;
    logic                rst_n           = 1'b0;
    logic                cfg_we          = 1'b0;
    logic                cfg_index       = CFG_TARGET_WIDTH;
    logic [TARGET_W-1:0] cfg_data        = '0;
    logic                in_valid        = 1'b0;
    logic                in_stall;
    logic                kind            = KIND_HEADER;
    logic [15:0]         reserved_word   = '0;
    logic [15:0]         type_word       = '0;
    logic [15:0]         entry_count     = '0;
    logic [LEN_W-1:0]    directory_bytes = '0;
    logic [7:0]          width_byte      = '0;
    logic [7:0]          height_byte     = '0;
    logic [15:0]         bit_count       = '0;
    logic                out_valid;
    logic                out_stall       = 1'b0;
    logic                found;
    logic [INDEX_W-1:0]  best_index;

    int                  mismatch_count;
    int                  results_due;

    logic                idle_on   = 1'b1;
    logic                rx_quiet  = 1'b0;
    logic                hold_arm  = 1'b0;
    logic                hold_done = 1'b0;
    int                  rx_left   = 0;
    int                  hold_left = 0;
    logic [TARGET_W-1:0] cur_w     = TARGET_RESET;
    logic [TARGET_W-1:0] cur_h     = TARGET_RESET;

    always #2 clk = ~clk;

    icon_size_best_match_unit u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_kind            (kind),
        .i_reserved_word   (reserved_word),
        .i_type_word       (type_word),
        .i_entry_count     (entry_count),
        .i_directory_bytes (directory_bytes),
        .i_width_byte      (width_byte),
        .i_height_byte     (height_byte),
        .i_bit_count       (bit_count),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_found           (found),
        .o_best_index      (best_index)
    );

    ism_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_kind            (kind),
        .i_reserved_word   (reserved_word),
        .i_type_word       (type_word),
        .i_entry_count     (entry_count),
        .i_directory_bytes (directory_bytes),
        .i_width_byte      (width_byte),
        .i_height_byte     (height_byte),
        .i_bit_count       (bit_count),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_found           (found),
        .i_best_index      (best_index),
        .o_fail_count      (mismatch_count),
        .o_pending         (results_due)
    );

    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver: random stall runs, one long hold-off when armed
    always @(negedge clk) begin
        if (rx_quiet || !rst_n) begin
            out_stall = 1'b0;
            rx_left   = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall = 1'b1;
        end else if (hold_arm && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall = 1'b1;
        end else if (rx_left > 0) begin
            rx_left--;
        end else if (out_stall) begin
            out_stall = 1'b0;
            rx_left   = $urandom_range(0, 10);
        end else begin
            rx_left = pick_gap();
            if (rx_left > 0) begin
                out_stall = 1'b1;
                rx_left--;
            end
        end
    end

    task automatic send_item(input logic k, input logic [15:0] rsv, input logic [15:0] typ,
                             input logic [15:0] cnt, input logic [LEN_W-1:0] len,
                             input logic [7:0] wb, input logic [7:0] hb,
                             input logic [15:0] bits);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        kind            = k;
        reserved_word   = rsv;
        type_word       = typ;
        entry_count     = cnt;
        directory_bytes = len;
        width_byte      = wb;
        height_byte     = hb;
        bit_count       = bits;
        in_valid        = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_header(input logic [15:0] rsv, input logic [15:0] typ,
                               input logic [15:0] cnt, input logic [LEN_W-1:0] len);
        send_item(KIND_HEADER, rsv, typ, cnt, len, 8'($urandom), 8'($urandom),
                  16'($urandom));
    endtask

    task automatic send_entry(input logic [7:0] wb, input logic [7:0] hb,
                              input logic [15:0] bits);
        send_item(KIND_ENTRY, 16'($urandom), 16'($urandom), 16'($urandom),
                  LEN_W'($urandom), wb, hb, bits);
    endtask

    function automatic logic [LEN_W-1:0] good_len(input int n);
        int unsigned v;
        v = 6 + 14 * n;
        case ($urandom_range(0, 3))
            0: v = v;
            1: v = v + $urandom_range(1, 13);
            2: v = v + $urandom_range(0, 100000);
            default: v = 20'hFFFFF;
        endcase
        if (v > 20'hFFFFF)
            v = 20'hFFFFF;
        return v[LEN_W-1:0];
    endfunction

    // edge bytes near the target so exact and tied entries show up often
    function automatic logic [7:0] rand_edge(input logic [TARGET_W-1:0] t);
        int r;
        r = $urandom_range(0, 9);
        if (r <= 2)
            return (t == 11'd256) ? 8'd0 : t[7:0];
        if (r == 3)
            return t[7:0] + 8'd1;
        if (r == 4)
            return t[7:0] - 8'd1;
        if (r == 5)
            return 8'd0;
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] rand_depth();
        case ($urandom_range(0, 7))
            0: return 16'd1;
            1: return 16'd8;
            2: return 16'd32;
            3: return 16'd0;
            4: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_dir(input int n, input int upto);
        send_header(16'd0, ICON_TYPE, 16'(n), good_len(n));
        for (int i = 0; i < upto; i++)
            send_entry(rand_edge(cur_w), rand_edge(cur_h), rand_depth());
    endtask

    task automatic send_bad_header();
        logic [15:0] v;
        int          c;
        case ($urandom_range(0, 5))
            0: send_header(16'($urandom_range(1, 65535)), ICON_TYPE,
                           16'($urandom_range(1, 5)), good_len(5));
            1: begin
                v = 16'($urandom);
                if (v == ICON_TYPE)
                    v = 16'd0;
                send_header(16'd0, v, 16'd1, good_len(1));
            end
            2: send_header(16'd0, ICON_TYPE, 16'd0, good_len(1));
            3: send_header(16'd0, ICON_TYPE, 16'($urandom), LEN_W'($urandom_range(0, 5)));
            4: begin
                c = $urandom_range(1, 4000);
                send_header(16'd0, ICON_TYPE, 16'(c),
                            LEN_W'(6 + 14 * c - $urandom_range(1, 14)));
            end
            default: send_header(16'($urandom), 16'($urandom), 16'($urandom),
                                 LEN_W'($urandom));
        endcase
    endtask

    task automatic run_phase(input int items);
        int sent;
        int n;
        int r;
        int cut;
        sent = 0;
        while (sent < items) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
                send_dir(n, n);
                sent += n + 1;
            end else if (r < 82) begin
                send_bad_header();
                sent++;
            end else if (r < 90) begin
                n   = $urandom_range(2, 8);
                cut = $urandom_range(0, n - 1);
                send_dir(n, cut);
                sent += cut + 1;
            end else begin
                send_entry(8'($urandom), 8'($urandom), 16'($urandom));
                sent++;
            end
        end
    endtask

    // wait until no item is in flight
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        rx_quiet = 1'b1;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [TARGET_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic set_target(input logic [TARGET_W-1:0] w, input logic [TARGET_W-1:0] h,
                              input logic idle);
        settle();
        write_cfg(CFG_TARGET_WIDTH, w);
        write_cfg(CFG_TARGET_HEIGHT, h);
        cur_w    = w;
        cur_h    = h;
        idle_on  = idle;
        rx_quiet = 1'b0;
    endtask

    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
                stuck = 0;
            else
                stuck++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // malformed headers
        send_header(16'hFFFF, ICON_TYPE, 1, 20);
        send_header(16'd0, 16'hFFFF, 1, 20);
        send_header(16'd0, 16'd0, 1, 20);
        send_header(16'd0, ICON_TYPE, 0, 20);
        send_header(16'd0, ICON_TYPE, 1, 5);
        send_header(16'd0, ICON_TYPE, 1, 0);
        send_header(16'd0, ICON_TYPE, 2, 33);
        // entry with no directory open
        send_entry(8'd16, 8'd16, 16'd32);
        // single exact entry, length at its minimum
        send_header(16'd0, ICON_TYPE, 1, 20);
        send_entry(8'd16, 8'd16, 16'd32);
        // all three classes, exact tie goes to the first
        send_header(16'd0, ICON_TYPE, 5, 20'hFFFFF);
        send_entry(8'd8, 8'd8, 16'hFFFF);
        send_entry(8'd0, 8'd0, 16'd1);
        send_entry(8'd17, 8'd16, 16'd4);
        send_entry(8'd16, 8'd16, 16'd8);
        send_entry(8'd16, 8'd16, 16'd8);
        // largest count, abandoned by a new header
        send_header(16'd0, ICON_TYPE, 16'hFFFF, 20'hFFFFF);
        send_entry(8'd255, 8'd255, 16'd0);
        send_header(16'd0, ICON_TYPE, 2, 34);
        send_entry(8'd32, 8'd32, 16'd8);
        send_entry(8'd32, 8'd32, 16'd24);
        // directory cut by a bad header
        send_header(16'd0, ICON_TYPE, 3, 48);
        send_entry(8'd8, 8'd16, 16'd4);
        send_header(16'd1, ICON_TYPE, 1, 20);
        // smaller entries tied
        send_header(16'd0, ICON_TYPE, 2, 34);
        send_entry(8'd15, 8'd15, 16'd8);
        send_entry(8'd15, 8'd15, 16'd8);

        hold_arm = 1'b1;
        run_phase(90);
        set_target(11'd1, 11'd1, 1'b0);
        run_phase(80);
        set_target(11'd1024, 11'd1024, 1'b1);
        run_phase(80);
        set_target(11'd0, 11'd0, 1'b1);
        run_phase(80);
        set_target(11'd2047, 11'd2047, 1'b0);
        run_phase(60);
        set_target(11'd256, 11'd256, 1'b1);
        run_phase(90);
        set_target(11'd48, 11'd32, 1'b1);
        run_phase(90);
        set_target(11'd32, 11'd48, 1'b0);
        run_phase(80);
        for (int p = 0; p < 3; p++) begin
            set_target(TARGET_W'($urandom_range(1, 300)), TARGET_W'($urandom_range(1, 300)),
                       1'b1);
            run_phase(70);
        end

        settle();
        if (mismatch_count == 0 && results_due == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
